FILE: sv/sdlf_pkg.sv
// ----------------------------------------------------------------------------
// sdlf_pkg
// Shared types, widths, character codes and helpers of the signed decimal
// line formatter.
// ----------------------------------------------------------------------------
package sdlf_pkg;

  localparam int VALUE_W     = 32;
  localparam int LABEL_W     = 64;
  localparam int LEN_W       = 4;
  localparam int MAG_W       = 32;
  localparam int DIGIT_W     = 4;
  localparam int LABEL_BYTES = 8;
  localparam int CHAR_W      = 8;

  localparam int DIGIT_COUNT_DEF     = 6;
  localparam int MAX_LABEL_CHARS_DEF = 8;
  localparam int FIELD_WIDTH_DEF     = 17;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LABEL_W-1:0]        label_chars;
    logic [LEN_W-1:0]          label_length;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              clamped;
  } out_item_t;

  typedef struct packed {
    logic               neg;
    logic               clamped;
    logic [LEN_W-1:0]   len;
    logic [LABEL_W-1:0] label;
    logic [MAG_W-1:0]   mag;
  } work_t;

  function automatic logic [MAG_W-1:0] pow10(input int n);
    logic [MAG_W-1:0] p;
    p = 32'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

endpackage

FILE: sv/sdlf_prep.sv
// ----------------------------------------------------------------------------
// sdlf_prep
// Sign split, magnitude, saturation and label length limit; one stage.
// ----------------------------------------------------------------------------
module sdlf_prep #(
  parameter int DIGIT_COUNT     = sdlf_pkg::DIGIT_COUNT_DEF,
  parameter int MAX_LABEL_CHARS = sdlf_pkg::MAX_LABEL_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  sdlf_pkg::in_item_t up_item,
  output logic               up_ready,
  output logic               dn_valid,
  output sdlf_pkg::work_t    dn_work,
  input  logic               dn_ready
);

  localparam logic [sdlf_pkg::MAG_W-1:0] LIMIT =
    sdlf_pkg::pow10(DIGIT_COUNT) - 32'd1;
  localparam logic [sdlf_pkg::LEN_W-1:0] MAX_LEN = sdlf_pkg::LEN_W'(MAX_LABEL_CHARS);

  logic                        v_r;
  sdlf_pkg::work_t             work_r;
  sdlf_pkg::work_t             work_nxt;
  logic [sdlf_pkg::MAG_W-1:0]  raw;
  logic [sdlf_pkg::MAG_W-1:0]  mag;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_work  = work_r;

  always_comb begin
    raw              = up_item.value;
    mag              = raw[sdlf_pkg::MAG_W-1] ? (32'd0 - raw) : raw;
    work_nxt.neg     = raw[sdlf_pkg::MAG_W-1];
    work_nxt.clamped = mag > LIMIT;
    work_nxt.mag     = (mag > LIMIT) ? LIMIT : mag;
    work_nxt.label   = up_item.label_chars;
    work_nxt.len     = (up_item.label_length > MAX_LEN) ? MAX_LEN : up_item.label_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work_r <= work_nxt;
    end
  end

endmodule

FILE: sv/sdlf_digit.sv
// ----------------------------------------------------------------------------
// sdlf_digit
// One decimal digit stage: peels the digit of weight 10^(DIGIT_COUNT-1-IDX).
// ----------------------------------------------------------------------------
module sdlf_digit #(
  parameter int DIGIT_COUNT = sdlf_pkg::DIGIT_COUNT_DEF,
  parameter int IDX         = 0
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         up_valid,
  input  sdlf_pkg::work_t                              up_work,
  input  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] up_digits,
  output logic                                         up_ready,
  output logic                                         dn_valid,
  output sdlf_pkg::work_t                              dn_work,
  output logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] dn_digits,
  input  logic                                         dn_ready
);

  localparam logic [sdlf_pkg::MAG_W-1:0] TOP = sdlf_pkg::pow10(DIGIT_COUNT - 1 - IDX);

  logic                                          v_r;
  sdlf_pkg::work_t                               work_r;
  sdlf_pkg::work_t                               work_nxt;
  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] digits_r;
  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] digits_nxt;
  logic [sdlf_pkg::DIGIT_W-1:0]                  dig;
  logic [sdlf_pkg::MAG_W-1:0]                    sub;

  assign up_ready  = !v_r || dn_ready;
  assign dn_valid  = v_r;
  assign dn_work   = work_r;
  assign dn_digits = digits_r;

  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (up_work.mag >= 32'(k) * TOP) begin
        dig = sdlf_pkg::DIGIT_W'(k);
        sub = 32'(k) * TOP;
      end
    end
    work_nxt        = up_work;
    work_nxt.mag    = up_work.mag - sub;
    digits_nxt      = up_digits;
    digits_nxt[IDX] = dig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work_r   <= work_nxt;
      digits_r <= digits_nxt;
    end
  end

endmodule

FILE: sv/sdlf_serial.sv
// ----------------------------------------------------------------------------
// sdlf_serial
// Line emitter: holds one formatted number and sends its line one character
// per cycle through a registered output.
// ----------------------------------------------------------------------------
module sdlf_serial #(
  parameter int DIGIT_COUNT = sdlf_pkg::DIGIT_COUNT_DEF,
  parameter int FIELD_WIDTH = sdlf_pkg::FIELD_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         up_valid,
  input  sdlf_pkg::work_t                              up_work,
  input  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] up_digits,
  output logic                                         up_ready,
  output logic                                         out_strobe,
  output sdlf_pkg::out_item_t                          out_item
);

  localparam int LINE_LEN = FIELD_WIDTH + 2;
  localparam int POS_W    = $clog2(LINE_LEN);
  localparam int DIDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [POS_W-1:0] LAST   = POS_W'(LINE_LEN - 1);
  localparam logic [POS_W-1:0] CR_POS = POS_W'(FIELD_WIDTH);

  logic                                                     act_r;
  logic [POS_W-1:0]                                         pos_r;
  logic [sdlf_pkg::LABEL_BYTES-1:0][sdlf_pkg::CHAR_W-1:0]   lbl_r;
  logic [sdlf_pkg::LEN_W-1:0]                               len_r;
  logic                                                     neg_r;
  logic                                                     clp_r;
  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0]            dig_r;
  logic [sdlf_pkg::LEN_W-1:0]                               fst_r;
  logic [sdlf_pkg::LEN_W-1:0]                               ndig_r;
  logic                                                     strobe_r;
  sdlf_pkg::out_item_t                                      out_r;

  logic                       last;
  logic                       load;
  logic [sdlf_pkg::LEN_W-1:0] fst_nxt;
  logic [POS_W-1:0]           lenp;
  logic [POS_W-1:0]           koff;
  logic [POS_W-1:0]           dsel;
  logic [DIDX_W-1:0]          didx;
  logic [sdlf_pkg::CHAR_W-1:0] ch;

  assign last       = act_r && (pos_r == LAST);
  assign up_ready   = !act_r || last;
  assign load       = up_valid && up_ready;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  // first printed digit: leading zeros suppressed, lone zero kept
  always_comb begin
    fst_nxt = sdlf_pkg::LEN_W'(DIGIT_COUNT - 1);
    for (int d = DIGIT_COUNT - 1; d >= 0; d--) begin
      if (up_digits[d] != '0) begin
        fst_nxt = sdlf_pkg::LEN_W'(d);
      end
    end
  end

  always_comb begin
    lenp = POS_W'(len_r);
    koff = pos_r - lenp - POS_W'(1);
    dsel = POS_W'(fst_r) + koff;
    didx = dsel[DIDX_W-1:0];
    if (pos_r == LAST) begin
      ch = sdlf_pkg::CH_LF;
    end else if (pos_r == CR_POS) begin
      ch = sdlf_pkg::CH_CR;
    end else if (pos_r < lenp) begin
      ch = lbl_r[pos_r[2:0]];
    end else if (pos_r == lenp) begin
      ch = neg_r ? sdlf_pkg::CH_MINUS : sdlf_pkg::CH_SPACE;
    end else if (koff < POS_W'(ndig_r)) begin
      ch = sdlf_pkg::CH_ZERO + {4'd0, dig_r[didx]};
    end else begin
      ch = sdlf_pkg::CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      pos_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= act_r;
      if (load) begin
        act_r <= 1'b1;
        pos_r <= '0;
      end else if (last) begin
        act_r <= 1'b0;
      end else if (act_r) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lbl_r  <= up_work.label;
      len_r  <= up_work.len;
      neg_r  <= up_work.neg;
      clp_r  <= up_work.clamped;
      dig_r  <= up_digits;
      fst_r  <= fst_nxt;
      ndig_r <= sdlf_pkg::LEN_W'(DIGIT_COUNT) - fst_nxt;
    end
    if (act_r) begin
      out_r.char_code <= ch;
      out_r.last_char <= last;
      out_r.clamped   <= clp_r;
    end
  end

`ifndef SYNTHESIS
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && !last |=> act_r && (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("line position skipped");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> pos_r <= LAST)
    else $error("line position out of range");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && out_r.last_char |-> $past(pos_r) == LAST)
    else $error("line end at wrong position");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> act_r && pos_r == '0)
    else $error("line load lost");
`endif

endmodule

FILE: sv/signed_decimal_line_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_line_formatter
// Path: input register, prep stage, digit stages, emitter output register.
// Throughput: one line of FIELD_WIDTH + 2 characters (19) per item; the
//   character emitter sets it, one character per cycle, lines back to back.
// The pipeline ahead of the emitter buffers DIGIT_COUNT + 2 further items.
// Reset: synchronous, active low; clears all valid bits, no line in flight.
// ----------------------------------------------------------------------------
module signed_decimal_line_formatter #(
  parameter int DIGIT_COUNT     = sdlf_pkg::DIGIT_COUNT_DEF,
  parameter int MAX_LABEL_CHARS = sdlf_pkg::MAX_LABEL_CHARS_DEF,
  parameter int FIELD_WIDTH     = sdlf_pkg::FIELD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sdlf_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output sdlf_pkg::out_item_t out_item
);

  logic               in_v_r;
  sdlf_pkg::in_item_t in_r;
  logic               prep_ready;
  logic               accept;

  logic                                          st_valid [DIGIT_COUNT+1];
  logic                                          st_ready [DIGIT_COUNT+1];
  sdlf_pkg::work_t                               st_work  [DIGIT_COUNT+1];
  logic [DIGIT_COUNT-1:0][sdlf_pkg::DIGIT_W-1:0] st_dig   [DIGIT_COUNT+1];

  assign busy   = in_v_r && !prep_ready;
  assign accept = start && !busy;
  assign st_dig[0] = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (prep_ready) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
  end

  sdlf_prep #(
    .DIGIT_COUNT     (DIGIT_COUNT),
    .MAX_LABEL_CHARS (MAX_LABEL_CHARS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_v_r),
    .up_item  (in_r),
    .up_ready (prep_ready),
    .dn_valid (st_valid[0]),
    .dn_work  (st_work[0]),
    .dn_ready (st_ready[0])
  );

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
    sdlf_digit #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .IDX         (g)
    ) u_digit (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (st_valid[g]),
      .up_work   (st_work[g]),
      .up_digits (st_dig[g]),
      .up_ready  (st_ready[g]),
      .dn_valid  (st_valid[g+1]),
      .dn_work   (st_work[g+1]),
      .dn_digits (st_dig[g+1]),
      .dn_ready  (st_ready[g+1])
    );
  end

  sdlf_serial #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (st_valid[DIGIT_COUNT]),
    .up_work    (st_work[DIGIT_COUNT]),
    .up_digits  (st_dig[DIGIT_COUNT]),
    .up_ready   (st_ready[DIGIT_COUNT]),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: verif/tb_signed_decimal_line_formatter.sv
// ----------------------------------------------------------------------------
// tb_signed_decimal_line_formatter
// Self-checking testbench for the signed decimal line formatter. A driver
// feeds directed and random items (values, labels, label lengths) through the
// start/busy handshake with random gaps. A line predictor builds the 19
// expected characters of each accepted item, and a monitor compares every
// strobed character against them in order.
// ----------------------------------------------------------------------------
module tb_signed_decimal_line_formatter;

  localparam int DIGITS     = sdlf_pkg::DIGIT_COUNT_DEF;
  localparam int LABEL_MAX  = sdlf_pkg::MAX_LABEL_CHARS_DEF;
  localparam int FIELD      = sdlf_pkg::FIELD_WIDTH_DEF;
  localparam int LINE_LEN   = FIELD + 2;
  localparam int MAG_MAX    = 999999;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_MAX  = 200000;
  localparam int RAND_ITEMS = 210;

  typedef struct {
    sdlf_pkg::in_item_t item;
    int                 gap;
    bit                 drain;
  } pending_item_t;

  typedef struct {
    sdlf_pkg::out_item_t ch;
    int                  line_no;
    int                  pos;
  } line_char_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  sdlf_pkg::in_item_t  in_item = '0;
  logic                out_strobe;
  sdlf_pkg::out_item_t out_item;

  pending_item_t item_q[$];
  line_char_t    line_char_q[$];
  pending_item_t cur;
  bit            have_cur = 1'b0;
  int            gap_left = 0;
  int            lines_sent = 0;
  int            fail_count = 0;
  int            cycles = 0;

  signed_decimal_line_formatter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_mismatch(string what, int line_no, int pos, int got, int want);
    $display("MISMATCH %s: line %0d char %0d got %0h expected %0h",
             what, line_no, pos, got, want);
    fail_count++;
  endtask

  // Builds the expected line for one accepted item.
  task automatic format_line(sdlf_pkg::in_item_t it);
    logic [31:0] raw;
    logic [31:0] mag;
    logic [7:0]  line [LINE_LEN];
    logic        neg;
    bit          clamp;
    bit          started;
    int          len;
    int          pos;
    int          div;
    int          dig;
    line_char_t  lc;
    raw = it.value;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    clamp = 1'b0;
    started = 1'b0;
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
      clamp = 1'b1;
    end
    len = int'(it.label_length);
    if (len > LABEL_MAX) len = LABEL_MAX;
    for (int i = 0; i < FIELD; i++) line[i] = sdlf_pkg::CH_SPACE;
    line[FIELD]     = sdlf_pkg::CH_CR;
    line[FIELD + 1] = sdlf_pkg::CH_LF;
    for (int i = 0; i < len; i++) begin
      if (i < FIELD) line[i] = it.label_chars[8*i +: 8];
    end
    if (len < FIELD) line[len] = neg ? sdlf_pkg::CH_MINUS : sdlf_pkg::CH_SPACE;
    pos = len + 1;
    div = 1;
    for (int i = 1; i < DIGITS; i++) div = div * 10;
    for (int d = 0; d < DIGITS; d++) begin
      dig = mag / div;
      mag = mag - dig * div;
      div = div / 10;
      if (dig != 0) started = 1'b1;
      if (started || d == DIGITS - 1) begin
        if (pos < FIELD) line[pos] = sdlf_pkg::CH_ZERO + 8'(dig);
        pos++;
      end
    end
    for (int i = 0; i < LINE_LEN; i++) begin
      lc.ch.char_code = line[i];
      lc.ch.last_char = (i == LINE_LEN - 1);
      lc.ch.clamped   = clamp;
      lc.line_no      = lines_sent;
      lc.pos          = i;
      line_char_q.push_back(lc);
    end
    lines_sent++;
  endtask

  // Driver: single nonblocking write per signal per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) format_line(in_item);
      if (!(start && busy)) begin
        if (!have_cur && item_q.size() > 0) begin
          cur = item_q.pop_front();
          have_cur = 1'b1;
          gap_left = cur.gap;
        end
        if (have_cur && gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (have_cur && (!cur.drain || line_char_q.size() == 0)) begin
          start   <= 1'b1;
          in_item <= cur.item;
          have_cur = 1'b0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    line_char_t lc;
    if (rst_n && out_strobe) begin
      if (line_char_q.size() == 0) begin
        note_mismatch("unexpected char", -1, -1, out_item.char_code, 0);
      end else begin
        lc = line_char_q.pop_front();
        if (out_item.char_code !== lc.ch.char_code)
          note_mismatch("char_code", lc.line_no, lc.pos, out_item.char_code,
                        lc.ch.char_code);
        if (out_item.last_char !== lc.ch.last_char)
          note_mismatch("last_char", lc.line_no, lc.pos, out_item.last_char,
                        lc.ch.last_char);
        if (out_item.clamped !== lc.ch.clamped)
          note_mismatch("clamped", lc.line_no, lc.pos, out_item.clamped,
                        lc.ch.clamped);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d chars outstanding", cycles,
               line_char_q.size());
      $display("** signed_decimal_line_formatter: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_item(int v, logic [63:0] label, int len, int gap, bit drain);
    pending_item_t p;
    p.item.value        = v;
    p.item.label_chars  = label;
    p.item.label_length = len[3:0];
    p.gap               = gap;
    p.drain             = drain;
    item_q.push_back(p);
  endtask

  function automatic int random_value();
    int v;
    int p;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, MAG_MAX);
      2: v = $urandom_range(0, 99);
      3: begin
        p = 1;
        repeat ($urandom_range(0, DIGITS)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      4: v = $urandom_range(MAG_MAX + 1, 2 * MAG_MAX);
      default: v = $urandom_range(0, 9999);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    int len;
    int gap;
    // directed: digit-count extremes, sign, saturation, label lengths
    add_item(0,            64'h0,                  0,  0, 1'b0);
    add_item(1,            64'h41,                 1,  0, 1'b0);
    add_item(-1,           64'h4241,               2,  0, 1'b0);
    add_item(9,            64'h0,                  3,  2, 1'b0);
    add_item(10,           64'h6463_6261,          4,  0, 1'b0);
    add_item(-99999,       64'h6564_6362_61,       5,  0, 1'b0);
    add_item(100000,       64'h4645_4443_4241,     6,  0, 1'b0);
    add_item(MAG_MAX,      64'h4746_4544_4342_41,  7,  0, 1'b0);
    add_item(-MAG_MAX,     64'h4847_4645_4443_4241, 8, 0, 1'b0);
    add_item(MAG_MAX + 1,  64'hFFFF_FFFF_FFFF_FFFF, 8, 0, 1'b0);
    add_item(-MAG_MAX - 1, 64'hFFFF_FFFF_FFFF_FFFF, 9, 5, 1'b0);
    add_item(32'h7FFF_FFFF, 64'h5A59_5857_5655_5453, 15, 0, 1'b1);
    add_item(32'h8000_0000, 64'h0,                 12, 0, 1'b0);
    add_item(123456,       64'h3A00_2000_7F00_0100, 8, 0, 1'b0);
    add_item(-42,          64'h2D30_2031_2032,     10, 0, 1'b0);
    add_item(-7,           64'h5A,                 1,  0, 1'b0);
    add_item(1000,         64'h4142_4344_4546_4748, 0, 0, 1'b0);
    add_item(-100000,      64'h4142_4344_4546_4748, 14, 30, 1'b0);
    add_item(-2,           64'h0,                  8,  0, 1'b1);
    add_item(5,            64'h8000_0000_0000_0080, 8, 0, 1'b0);
    // random
    for (int i = 0; i < RAND_ITEMS; i++) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
      gap = ((i / 20) % 3 == 0) ? 0 : pick_gap();
      add_item(random_value(), {$urandom, $urandom}, len, gap, (i % 60) == 59);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (item_q.size() != 0 || have_cur || start || line_char_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("** signed_decimal_line_formatter: PASSED **");
    end else begin
      $display("** signed_decimal_line_formatter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sdlf_pkg.sv
sv/sdlf_prep.sv
sv/sdlf_digit.sv
sv/sdlf_serial.sv
sv/signed_decimal_line_formatter.sv
verif/tb_signed_decimal_line_formatter.sv
